// File: rtl/osmc_pkg.sv
// Shared types and constants for the occupancy schedule mode controller.
// Used by the top level. No dependencies.
package osmc_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE        = 3'd0,
    MODE_ACTIVE      = 3'd1,
    MODE_TRANSITION  = 3'd2,
    MODE_AFTER_HOURS = 3'd3,
    MODE_WEEKEND     = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    CMD_START        = 3'd0,
    CMD_TIME_CHECK   = 3'd1,
    CMD_SCAN         = 3'd2,
    CMD_REPORT_QUERY = 3'd3,
    CMD_REPORT_DONE  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    REG_OFFICE_START  = 3'd0,
    REG_OFFICE_END    = 3'd1,
    REG_TRANS_HOLD    = 3'd2,
    REG_IDLE_IV       = 3'd3,
    REG_ACTIVE_IV     = 3'd4,
    REG_TRANS_IV      = 3'd5,
    REG_AFTER_IV      = 3'd6,
    REG_WEEKEND_IV    = 3'd7
  } reg_idx_t;

  localparam int unsigned DAY_SATURDAY = 5;
  localparam int unsigned DAY_SUNDAY   = 6;
  localparam int unsigned MINUTES_PER_HOUR = 60;

  localparam logic [10:0] OFFICE_START_RST = 11'd480;
  localparam logic [10:0] OFFICE_END_RST   = 11'd1020;
  localparam logic [31:0] TRANS_HOLD_RST   = 32'd60000;
  localparam logic [63:0] DAY_IV_RST       = 64'd257698037760005000;
  localparam logic [63:0] OFF_IV_RST       = 64'd1546188226560060000;

endpackage

// File: rtl/occupancy_schedule_mode_controller.sv
// Occupancy schedule mode controller: input register, one pass of mode logic,
// result register, and an APB-style register file. Depends on osmc_pkg.
//
//  channel   signals                                   direction
//  request   req_valid/req_stall + command..reported    into block
//  result    res_valid/res_stall + mode..presence_led   out of block
//  config    psel/penable/pwrite/paddr/pwdata/prdata    APB slave
//
// A request is captured in the input register, evaluated combinationally and
// written to the result register; one request per cycle while req_stall is low.
// The mode state updates together with the result register.
// Sync active-high reset clears mode state, pend, res_valid; loads config.
// req_stall rises only while both the input and result registers are full
// and res_stall is high.
module occupancy_schedule_mode_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  command,
  input  logic [31:0] now_ms,
  input  logic [4:0]  hour,
  input  logic [5:0]  minute,
  input  logic [2:0]  day_of_week,
  input  logic        occupancy,
  input  logic        force_report,
  input  logic        reported_presence,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  mode,
  output logic        mode_changed,
  output logic        scan_ran,
  output logic        report_due,
  output logic        presence_led,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import osmc_pkg::*;

  logic [10:0] office_start;
  logic [10:0] office_end;
  logic [31:0] trans_hold;
  logic [63:0] iv_idle, iv_active, iv_trans, iv_after, iv_weekend;
  logic [2:0]  reg_sel;
  logic        cfg_wr;

  logic        pend;
  logic [2:0]  p_command;
  logic [31:0] p_now;
  logic [4:0]  p_hour;
  logic [5:0]  p_minute;
  logic [2:0]  p_day;
  logic        p_occ;
  logic        p_force;
  logic        p_rep;

  mode_t       cur_mode, cur_mode_next;
  logic [31:0] mode_stamp, mode_stamp_next;
  logic [31:0] scan_stamp, scan_stamp_next;
  logic [31:0] report_stamp, report_stamp_next;
  logic        last_level, last_level_next;
  logic        led, led_next;
  logic        changed, scanned, due;

  logic        accept, fire;
  logic [63:0] mode_iv;
  logic [10:0] tod;
  logic        weekend, in_window, off_hours;
  mode_t       tc_mode;
  mode_t       scan_mode;
  logic [31:0] rs_eff;

  assign pready = 1'b1;
  assign reg_sel = paddr[5:3];
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      office_start <= OFFICE_START_RST;
      office_end   <= OFFICE_END_RST;
      trans_hold   <= TRANS_HOLD_RST;
      iv_idle      <= DAY_IV_RST;
      iv_active    <= DAY_IV_RST;
      iv_trans     <= DAY_IV_RST;
      iv_after     <= OFF_IV_RST;
      iv_weekend   <= OFF_IV_RST;
    end else if (cfg_wr) begin
      case (reg_idx_t'(reg_sel))
        REG_OFFICE_START: office_start <= pwdata[10:0];
        REG_OFFICE_END:   office_end   <= pwdata[10:0];
        REG_TRANS_HOLD:   trans_hold   <= pwdata[31:0];
        REG_IDLE_IV:      iv_idle      <= pwdata;
        REG_ACTIVE_IV:    iv_active    <= pwdata;
        REG_TRANS_IV:     iv_trans     <= pwdata;
        REG_AFTER_IV:     iv_after     <= pwdata;
        REG_WEEKEND_IV:   iv_weekend   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(reg_sel))
      REG_OFFICE_START: prdata = {53'd0, office_start};
      REG_OFFICE_END:   prdata = {53'd0, office_end};
      REG_TRANS_HOLD:   prdata = {32'd0, trans_hold};
      REG_IDLE_IV:      prdata = iv_idle;
      REG_ACTIVE_IV:    prdata = iv_active;
      REG_TRANS_IV:     prdata = iv_trans;
      REG_AFTER_IV:     prdata = iv_after;
      REG_WEEKEND_IV:   prdata = iv_weekend;
      default:          prdata = 64'd0;
    endcase
  end

  assign fire      = pend && !(res_valid && res_stall);
  assign req_stall = pend && res_valid && res_stall;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (accept) begin
      pend <= 1'b1;
    end else if (fire) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_command <= command;
      p_now     <= now_ms;
      p_hour    <= hour;
      p_minute  <= minute;
      p_day     <= day_of_week;
      p_occ     <= occupancy;
      p_force   <= force_report;
      p_rep     <= reported_presence;
    end
  end

  always_comb begin
    case (cur_mode)
      MODE_IDLE:        mode_iv = iv_idle;
      MODE_ACTIVE:      mode_iv = iv_active;
      MODE_TRANSITION:  mode_iv = iv_trans;
      MODE_AFTER_HOURS: mode_iv = iv_after;
      MODE_WEEKEND:     mode_iv = iv_weekend;
      default:          mode_iv = 64'd0;
    endcase
  end

  assign off_hours = (cur_mode == MODE_AFTER_HOURS) || (cur_mode == MODE_WEEKEND);
  assign tod = 11'(p_hour) * 11'(MINUTES_PER_HOUR) + 11'(p_minute);
  assign weekend = (p_day == 3'(DAY_SATURDAY)) || (p_day == 3'(DAY_SUNDAY));
  assign in_window = (tod >= office_start) && (tod <= office_end);

  always_comb begin
    if (weekend) begin
      tc_mode = MODE_WEEKEND;
    end else if (!in_window) begin
      tc_mode = off_hours ? cur_mode : MODE_AFTER_HOURS;
    end else begin
      tc_mode = off_hours ? MODE_IDLE : cur_mode;
    end
  end

  always_comb begin
    if (p_occ && cur_mode != MODE_ACTIVE) begin
      scan_mode = MODE_ACTIVE;
    end else if (!p_occ && cur_mode == MODE_ACTIVE) begin
      scan_mode = MODE_TRANSITION;
    end else begin
      scan_mode = cur_mode;
    end
  end

  assign rs_eff = p_force ? 32'd0 : report_stamp;

  always_comb begin
    cur_mode_next     = cur_mode;
    mode_stamp_next   = mode_stamp;
    scan_stamp_next   = scan_stamp;
    report_stamp_next = report_stamp;
    last_level_next   = last_level;
    led_next          = led;
    changed           = 1'b0;
    scanned           = 1'b0;
    due               = 1'b0;
    case (cmd_t'(p_command))
      CMD_START, CMD_TIME_CHECK: begin
        if (cmd_t'(p_command) == CMD_START) begin
          led_next          = 1'b0;
          mode_stamp_next   = p_now;
          scan_stamp_next   = p_now;
          report_stamp_next = p_now;
        end
        if (tc_mode != cur_mode) begin
          cur_mode_next   = tc_mode;
          mode_stamp_next = p_now;
          changed         = 1'b1;
        end
      end
      CMD_SCAN: begin
        if ((p_now - scan_stamp) >= mode_iv[31:0]) begin
          scanned         = 1'b1;
          scan_stamp_next = p_now;
          led_next        = p_occ;
          if (!off_hours) begin
            if (scan_mode != cur_mode) begin
              cur_mode_next   = scan_mode;
              mode_stamp_next = p_now;
              changed         = 1'b1;
            end
            if (scan_mode == MODE_TRANSITION &&
                (p_now - mode_stamp_next) >= trans_hold) begin
              cur_mode_next   = MODE_IDLE;
              mode_stamp_next = p_now;
              changed         = 1'b1;
            end
          end
        end
      end
      CMD_REPORT_QUERY: begin
        report_stamp_next = rs_eff;
        if ((p_now - rs_eff) >= mode_iv[63:32] &&
            ((p_occ != last_level) || off_hours || p_force)) begin
          due = 1'b1;
        end
      end
      CMD_REPORT_DONE: begin
        report_stamp_next = p_now;
        last_level_next   = p_rep;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mode     <= MODE_IDLE;
      mode_stamp   <= 32'd0;
      scan_stamp   <= 32'd0;
      report_stamp <= 32'd0;
      last_level   <= 1'b0;
      led          <= 1'b0;
    end else if (fire) begin
      cur_mode     <= cur_mode_next;
      mode_stamp   <= mode_stamp_next;
      scan_stamp   <= scan_stamp_next;
      report_stamp <= report_stamp_next;
      last_level   <= last_level_next;
      led          <= led_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      mode         <= cur_mode_next;
      mode_changed <= changed;
      scan_ran     <= scanned;
      report_due   <= due;
      presence_led <= led_next;
    end
  end

endmodule

// File: rtl/osmc_check.sv
// Port-level checker for the occupancy schedule mode controller and its bind.
// Sees only top-level ports; depends on the top level being compiled first.
module osmc_check (
  input logic       clk,
  input logic       rst,
  input logic       req_stall,
  input logic       res_valid,
  input logic       res_stall,
  input logic [2:0] mode,
  input logic       mode_changed,
  input logic       scan_ran,
  input logic       report_due,
  input logic       presence_led
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> $stable(mode) && $stable(mode_changed) &&
      $stable(scan_ran) && $stable(report_due) && $stable(presence_led))
    else $error("stalled result changed");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !req_stall)
    else $error("request stalled with empty result register");

  a_report_alone: assert property (@(posedge clk) disable iff (rst)
    res_valid && report_due |-> !scan_ran && !mode_changed)
    else $error("report query flagged scan or mode change");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind occupancy_schedule_mode_controller osmc_check u_osmc_check (.*);
